// ----- hw/rtl/lrgbok_pkg.sv -----
`default_nettype none
package lrgbok_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CH_W       = FRAC_BITS + 2;
  localparam int COEF_BITS  = 24;
  localparam int COEF_W     = 28;
  localparam int MID_W      = FRAC_BITS + 4;
  localparam int MAG_W      = MID_W - 1;
  localparam int Y_W        = FRAC_BITS + 1;
  localparam int SRCH_STEPS = FRAC_BITS + 1;
  localparam int SQ_W       = 2 * Y_W - FRAC_BITS;
  localparam int XSQ_W      = 2 * MAG_W - FRAC_BITS;
  localparam int CUBE_W     = XSQ_W + MAG_W - FRAC_BITS;
  localparam int MID2_W     = CUBE_W + 1;
  localparam int P1_W       = CH_W + COEF_W;
  localparam int S1_W       = P1_W + 2;
  localparam int P2_W       = MID2_W + COEF_W;
  localparam int S2_W       = P2_W + 2;
  localparam int RES_W      = S2_W - COEF_BITS;
  localparam int TDATA_W    = ((3 * CH_W + 7) / 8) * 8;
  localparam int NSTG       = 8 + 2 * SRCH_STEPS;

  localparam longint unsigned DEC_SCALE = 64'd10000000000;
  localparam longint RND_HALF = longint'(1) << (COEF_BITS - 1);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t mat_t [9];

  function automatic coef_t coef_fixed(input longint c10);
    longint unsigned mag;
    longint unsigned q;
    mag = (c10 < 0) ? longint'(-c10) : longint'(c10);
    q = (mag * (64'd1 << COEF_BITS) + DEC_SCALE / 2) / DEC_SCALE;
    return (c10 < 0) ? coef_t'(-longint'(q)) : coef_t'(q);
  endfunction

  localparam mat_t FWD_M1 = '{
    coef_fixed(64'sd4122214708), coef_fixed(64'sd5363325363), coef_fixed(64'sd514459929),
    coef_fixed(64'sd2119034982), coef_fixed(64'sd6806995451), coef_fixed(64'sd1073969566),
    coef_fixed(64'sd883024619),  coef_fixed(64'sd2817188376), coef_fixed(64'sd6299787005)
  };
  localparam mat_t FWD_M2 = '{
    coef_fixed(64'sd2104542553),  coef_fixed(64'sd7936177850),   coef_fixed(-64'sd40720468),
    coef_fixed(64'sd19779984951), coef_fixed(-64'sd24285922050), coef_fixed(64'sd4505937099),
    coef_fixed(64'sd259040371),   coef_fixed(64'sd7827717662),   coef_fixed(-64'sd8086757660)
  };
  localparam mat_t INV_M1 = '{
    coef_fixed(64'sd10000000000), coef_fixed(64'sd3963377774),  coef_fixed(64'sd2158037573),
    coef_fixed(64'sd10000000000), coef_fixed(-64'sd1055613458), coef_fixed(-64'sd638541728),
    coef_fixed(64'sd10000000000), coef_fixed(-64'sd894841775),  coef_fixed(-64'sd12914855480)
  };
  localparam mat_t INV_M2 = '{
    coef_fixed(64'sd40767416621),  coef_fixed(-64'sd33077115913), coef_fixed(64'sd2309699292),
    coef_fixed(-64'sd12684380046), coef_fixed(64'sd26097574011),  coef_fixed(-64'sd3413193965),
    coef_fixed(-64'sd41960863),    coef_fixed(-64'sd7034186147),  coef_fixed(64'sd17076147010)
  };

  localparam logic signed [RES_W-1:0] CH_HI = RES_W'((longint'(1) << (CH_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] CH_LO = RES_W'(-(longint'(1) << (CH_W - 1)));

endpackage
`default_nettype wire

// ----- hw/rtl/linear_rgb_oklab_converter_top.sv -----
// Pipeline: NSTG = 8 + 2*(FRAC_BITS+1) register stages (42 at Q2.16).
// Throughput: one pixel per cycle; every stage advances together unless the
// output register holds a result that is not taken.
// The cube root spends two stages per result bit, one multiply in each.
// Reset (rst, synchronous): clears all valid bits and sets direction to 0.
`default_nettype none
module linear_rgb_oklab_converter_top
  import lrgbok_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // in_c0, in_c1, in_c2, zero pad
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // out_c0, out_c1, out_c2, zero pad
  output logic [0:0]         m_axis_tuser    // saturated
);

  logic            direction;
  logic [NSTG-1:0] vld;
  logic            en;

  assign cfg_ready     = 1'b1;
  assign en            = !vld[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_valid) begin
      direction <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], s_axis_tvalid};
    end
  end

  // first matrix
  logic signed [CH_W-1:0]  x_in [3];
  coef_t                   c1 [9];
  coef_t                   c2 [9];
  logic signed [P1_W-1:0]  p1 [9];
  logic signed [S1_W-1:0]  s1 [3];
  logic signed [MID_W-1:0] mid [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      x_in[l] = s_axis_tdata[l*CH_W +: CH_W];
    end
    for (int i = 0; i < 9; i++) begin
      c1[i] = direction ? INV_M1[i] : FWD_M1[i];
      c2[i] = direction ? INV_M2[i] : FWD_M2[i];
    end
    for (int r = 0; r < 3; r++) begin
      s1[r] = S1_W'(p1[3*r]) + S1_W'(p1[3*r+1]) + S1_W'(p1[3*r+2]) + S1_W'(RND_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        p1[i] <= P1_W'(x_in[i%3]) * P1_W'(c1[i]);
      end
      for (int r = 0; r < 3; r++) begin
        mid[r] <= s1[r][COEF_BITS +: MID_W];
      end
    end
  end

  // cube root search
  logic [MAG_W-1:0] srch_mag [SRCH_STEPS+1][3];
  logic             srch_sgn [SRCH_STEPS+1][3];
  logic [Y_W-1:0]   srch_y   [SRCH_STEPS+1][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        srch_sgn[0][l] <= mid[l][MID_W-1];
        srch_mag[0][l] <= mid[l][MID_W-1] ? MAG_W'(-mid[l]) : MAG_W'(mid[l]);
        srch_y[0][l]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < SRCH_STEPS; k++) begin : g_step
    localparam int B = FRAC_BITS - k;
    logic [Y_W-1:0]      t    [3];
    logic [2*Y_W-1:0]    tsq  [3];
    logic [Y_W-1:0]      ta   [3];
    logic [SQ_W-1:0]     sqa  [3];
    logic [MAG_W-1:0]    ma   [3];
    logic                sa   [3];
    logic [SQ_W+Y_W-1:0] prod [3];
    logic                fits [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l]    = srch_y[k][l] | (Y_W'(1) << B);
        tsq[l]  = (2*Y_W)'(t[l]) * (2*Y_W)'(t[l]);
        prod[l] = (SQ_W+Y_W)'(sqa[l]) * (SQ_W+Y_W)'(ta[l]);
        fits[l] = (SQ_W+Y_W)'(prod[l] >> FRAC_BITS) <= (SQ_W+Y_W)'(ma[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          ta[l]  <= t[l];
          sqa[l] <= tsq[l][FRAC_BITS +: SQ_W];
          ma[l]  <= srch_mag[k][l];
          sa[l]  <= srch_sgn[k][l];
          srch_mag[k+1][l] <= ma[l];
          srch_sgn[k+1][l] <= sa[l];
          srch_y[k+1][l]   <= fits[l] ? ta[l] : (ta[l] & ~(Y_W'(1) << B));
        end
      end
    end
  end

  // cube, sign, select
  logic [XSQ_W-1:0]         xsq  [3];
  logic [MAG_W-1:0]         xm   [3];
  logic [Y_W-1:0]           xy   [3];
  logic                     xs   [3];
  logic [2*MAG_W-1:0]       msq  [3];
  logic [XSQ_W+MAG_W-1:0]   xprod [3];
  logic signed [MID2_W-1:0] val  [3];
  logic signed [MID2_W-1:0] mid2 [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      msq[l]   = (2*MAG_W)'(srch_mag[SRCH_STEPS][l]) * (2*MAG_W)'(srch_mag[SRCH_STEPS][l]);
      xprod[l] = (XSQ_W+MAG_W)'(xsq[l]) * (XSQ_W+MAG_W)'(xm[l]);
      val[l]   = direction ? MID2_W'(xprod[l][FRAC_BITS +: CUBE_W]) : MID2_W'(xy[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        xsq[l]  <= msq[l][FRAC_BITS +: XSQ_W];
        xm[l]   <= srch_mag[SRCH_STEPS][l];
        xy[l]   <= srch_y[SRCH_STEPS][l];
        xs[l]   <= srch_sgn[SRCH_STEPS][l];
        mid2[l] <= xs[l] ? -val[l] : val[l];
      end
    end
  end

  // second matrix, saturate
  logic signed [P2_W-1:0]  p2 [9];
  logic signed [S2_W-1:0]  s2 [3];
  logic signed [RES_W-1:0] res [3];
  logic [CH_W-1:0]         out_c [3];
  logic                    out_sat;
  logic [CH_W-1:0]         clip [3];
  logic [2:0]              clip_hit;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s2[r] = S2_W'(p2[3*r]) + S2_W'(p2[3*r+1]) + S2_W'(p2[3*r+2]) + S2_W'(RND_HALF);
      if (res[r] > CH_HI) begin
        clip[r]     = CH_HI[CH_W-1:0];
        clip_hit[r] = 1'b1;
      end else if (res[r] < CH_LO) begin
        clip[r]     = CH_LO[CH_W-1:0];
        clip_hit[r] = 1'b1;
      end else begin
        clip[r]     = res[r][CH_W-1:0];
        clip_hit[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        p2[i] <= P2_W'(mid2[i%3]) * P2_W'(c2[i]);
      end
      for (int r = 0; r < 3; r++) begin
        res[r]   <= s2[r][COEF_BITS +: RES_W];
        out_c[r] <= clip[r];
      end
      out_sat <= |clip_hit;
    end
  end

  assign m_axis_tdata = {(TDATA_W-3*CH_W)'(0), out_c[2], out_c[1], out_c[0]};
  assign m_axis_tuser = out_sat;

endmodule
`default_nettype wire

// ----- hw/rtl/lrgbok_checker.sv -----
`default_nettype none
module lrgbok_checker
  import lrgbok_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]         m_axis_tuser
);

  localparam logic [CH_W-1:0] HI_CODE = CH_HI[CH_W-1:0];
  localparam logic [CH_W-1:0] LO_CODE = CH_LO[CH_W-1:0];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled transfer changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[CH_W-1:0] == HI_CODE || m_axis_tdata[CH_W-1:0] == LO_CODE ||
      m_axis_tdata[2*CH_W-1:CH_W] == HI_CODE || m_axis_tdata[2*CH_W-1:CH_W] == LO_CODE ||
      m_axis_tdata[3*CH_W-1:2*CH_W] == HI_CODE || m_axis_tdata[3*CH_W-1:2*CH_W] == LO_CODE)
    else $error("saturated flag without clamped channel");

endmodule

bind linear_rgb_oklab_converter_top lrgbok_checker u_lrgbok_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
